FILE: hdl/tkms_pkg.sv
package tkms_pkg;

    localparam int KEY_BITS      = 32;
    localparam int TAG_BITS      = 16;
    localparam int ENTRY_BITS    = KEY_BITS + TAG_BITS;
    localparam int MAX_ITEMS_DEF = 64;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] key_value;
        logic        [TAG_BITS-1:0] tag_value;
        logic                       last_item;
    } tkms_in_t;

    typedef struct packed {
        logic signed [KEY_BITS-1:0] sorted_key;
        logic        [TAG_BITS-1:0] sorted_tag;
        logic                       end_of_run;
        logic                       overflowed;
    } tkms_out_t;

    typedef enum logic [3:0] {
        ST_COLLECT,
        ST_SORT_INIT,
        ST_PASS_CHECK,
        ST_RUN_SETUP,
        ST_MERGE_RD,
        ST_MERGE_WR,
        ST_EMIT_RD,
        ST_EMIT_LOAD,
        ST_EMIT_SHOW
    } tkms_state_t;

    typedef struct packed {
        logic load;
        logic sort_init;
        logic pass_end;
        logic run_setup;
        logic merge_read;
        logic merge_write;
        logic emit_init;
        logic emit_read;
        logic emit_load;
        logic emit_next;
    } tkms_cmd_t;

    typedef struct packed {
        logic in_last;
        logic sorted;
        logic run_none;
        logic merge_last;
        logic emit_last;
    } tkms_sts_t;

endpackage

FILE: hdl/tkms_ram.sv
module tkms_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr_a,
    input  logic [ADDR_W-1:0] rd_addr_b,
    output logic [WIDTH-1:0]  rd_data_a,
    output logic [WIDTH-1:0]  rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

FILE: hdl/tkms_datapath.sv
module tkms_datapath #(
    parameter int MAX_ITEMS = 64
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tkms_pkg::tkms_in_t  s_data,
    input  tkms_pkg::tkms_cmd_t cmd,
    output tkms_pkg::tkms_sts_t sts,
    output tkms_pkg::tkms_out_t m_data
);
    import tkms_pkg::*;

    localparam int ADDR_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ITEMS + 1);
    localparam int RUN_W  = CNT_W + 2;

    logic [CNT_W-1:0] fill_reg, run_lo_reg, il_reg, le_reg, ir_reg, re_reg, k_reg;
    logic [CNT_W-1:0] emit_idx_reg;
    logic [RUN_W-1:0] width_reg;
    logic             ovf_reg;
    logic             src_sel_reg;
    tkms_out_t        out_reg;

    logic                      full;
    logic [RUN_W-1:0]          fill_ext, mid_sum, end_sum;
    logic [CNT_W-1:0]          le_next, re_next, k_inc, emit_inc;
    logic [ENTRY_BITS-1:0]     a_rd_a, a_rd_b, b_rd_a, b_rd_b;
    logic [ENTRY_BITS-1:0]     data_l, data_r, merge_data, a_wr_data;
    logic [ADDR_W-1:0]         a_wr_addr, rd_addr_a;
    logic signed [KEY_BITS-1:0] key_l, key_r;
    logic                      take_left, a_we, b_we, rd_en;

    assign full     = (fill_reg == CNT_W'(MAX_ITEMS));
    assign fill_ext = RUN_W'(fill_reg);
    assign mid_sum  = RUN_W'(run_lo_reg) + width_reg;
    assign end_sum  = mid_sum + width_reg;
    assign le_next  = (mid_sum < fill_ext) ? mid_sum[CNT_W-1:0] : fill_reg;
    assign re_next  = (end_sum < fill_ext) ? end_sum[CNT_W-1:0] : fill_reg;
    assign k_inc    = k_reg + CNT_W'(1);
    assign emit_inc = emit_idx_reg + CNT_W'(1);

    // src_sel_reg names the bank holding the current data; merges write the other
    assign data_l = src_sel_reg ? b_rd_a : a_rd_a;
    assign data_r = src_sel_reg ? b_rd_b : a_rd_b;
    assign key_l  = data_l[ENTRY_BITS-1:TAG_BITS];
    assign key_r  = data_r[ENTRY_BITS-1:TAG_BITS];

    // strict less-than: ties go to the right run
    assign take_left  = (il_reg < le_reg) && ((ir_reg >= re_reg) || (key_l < key_r));
    assign merge_data = take_left ? data_l : data_r;

    assign a_we      = (cmd.load && !full) || (cmd.merge_write && src_sel_reg);
    assign b_we      = cmd.merge_write && !src_sel_reg;
    assign a_wr_addr = cmd.load ? fill_reg[ADDR_W-1:0] : k_reg[ADDR_W-1:0];
    assign a_wr_data = cmd.load ? {s_data.key_value, s_data.tag_value} : merge_data;
    assign rd_en     = cmd.merge_read || cmd.emit_read;
    assign rd_addr_a = cmd.emit_read ? emit_idx_reg[ADDR_W-1:0] : il_reg[ADDR_W-1:0];

    tkms_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_ITEMS), .ADDR_W(ADDR_W)) u_store (
        .aclk      (aclk),
        .we        (a_we),
        .wr_addr   (a_wr_addr),
        .wr_data   (a_wr_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (ir_reg[ADDR_W-1:0]),
        .rd_data_a (a_rd_a),
        .rd_data_b (a_rd_b)
    );

    tkms_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_ITEMS), .ADDR_W(ADDR_W)) u_scratch (
        .aclk      (aclk),
        .we        (b_we),
        .wr_addr   (k_reg[ADDR_W-1:0]),
        .wr_data   (merge_data),
        .rd_en     (rd_en),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (ir_reg[ADDR_W-1:0]),
        .rd_data_a (b_rd_a),
        .rd_data_b (b_rd_b)
    );

    always_comb begin
        sts.in_last    = s_data.last_item;
        sts.sorted     = (width_reg >= fill_ext);
        sts.run_none   = (run_lo_reg >= fill_reg);
        sts.merge_last = (k_inc == re_reg);
        sts.emit_last  = (emit_inc == fill_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg     <= '0;
            ovf_reg      <= 1'b0;
            width_reg    <= '0;
            src_sel_reg  <= 1'b0;
            run_lo_reg   <= '0;
            il_reg       <= '0;
            le_reg       <= '0;
            ir_reg       <= '0;
            re_reg       <= '0;
            k_reg        <= '0;
            emit_idx_reg <= '0;
        end else begin
            if (cmd.load) begin
                if (full) begin
                    ovf_reg <= 1'b1;
                end else begin
                    fill_reg <= fill_reg + CNT_W'(1);
                end
            end
            if (cmd.sort_init) begin
                width_reg   <= RUN_W'(1);
                src_sel_reg <= 1'b0;
                run_lo_reg  <= '0;
            end
            if (cmd.pass_end) begin
                width_reg   <= width_reg << 1;
                src_sel_reg <= !src_sel_reg;
                run_lo_reg  <= '0;
            end
            if (cmd.run_setup) begin
                il_reg     <= run_lo_reg;
                le_reg     <= le_next;
                ir_reg     <= le_next;
                re_reg     <= re_next;
                k_reg      <= run_lo_reg;
                run_lo_reg <= re_next;
            end
            if (cmd.merge_write) begin
                k_reg <= k_inc;
                if (take_left) begin
                    il_reg <= il_reg + CNT_W'(1);
                end else begin
                    ir_reg <= ir_reg + CNT_W'(1);
                end
            end
            if (cmd.emit_init) begin
                emit_idx_reg <= '0;
            end
            if (cmd.emit_next) begin
                emit_idx_reg <= emit_inc;
                if (sts.emit_last) begin
                    fill_reg <= '0;
                    ovf_reg  <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_load) begin
            out_reg.sorted_key <= key_l;
            out_reg.sorted_tag <= data_l[TAG_BITS-1:0];
            out_reg.end_of_run <= sts.emit_last;
            out_reg.overflowed <= ovf_reg;
        end
    end

    assign m_data = out_reg;

endmodule

FILE: hdl/tkms_ctrl.sv
module tkms_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  tkms_pkg::tkms_sts_t sts,
    output tkms_pkg::tkms_cmd_t cmd
);
    import tkms_pkg::*;

    tkms_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT: begin
                if (s_valid && sts.in_last) begin
                    state_next = ST_SORT_INIT;
                end
            end
            ST_SORT_INIT:  state_next = ST_PASS_CHECK;
            ST_PASS_CHECK: state_next = sts.sorted ? ST_EMIT_RD : ST_RUN_SETUP;
            ST_RUN_SETUP:  state_next = sts.run_none ? ST_PASS_CHECK : ST_MERGE_RD;
            ST_MERGE_RD:   state_next = ST_MERGE_WR;
            ST_MERGE_WR:   state_next = sts.merge_last ? ST_RUN_SETUP : ST_MERGE_RD;
            ST_EMIT_RD:    state_next = ST_EMIT_LOAD;
            ST_EMIT_LOAD:  state_next = ST_EMIT_SHOW;
            ST_EMIT_SHOW: begin
                if (m_ready) begin
                    state_next = sts.emit_last ? ST_COLLECT : ST_EMIT_RD;
                end
            end
            default:       state_next = ST_COLLECT;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        m_valid = 1'b0;
        case (state_reg)
            ST_COLLECT: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_SORT_INIT:  cmd.sort_init = 1'b1;
            ST_PASS_CHECK: cmd.emit_init = sts.sorted;
            ST_RUN_SETUP: begin
                cmd.pass_end  = sts.run_none;
                cmd.run_setup = !sts.run_none;
            end
            ST_MERGE_RD:   cmd.merge_read = 1'b1;
            ST_MERGE_WR:   cmd.merge_write = 1'b1;
            ST_EMIT_RD:    cmd.emit_read = 1'b1;
            ST_EMIT_LOAD:  cmd.emit_load = 1'b1;
            ST_EMIT_SHOW: begin
                m_valid       = 1'b1;
                cmd.emit_next = m_ready;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hdl/tagged_key_merge_sorter_unit.sv
// Channel  | Ports                      | Beat
// ---------+----------------------------+---------------------------------------------
// input    | s_valid, s_ready, s_data   | key_value, tag_value, last_item
// result   | m_valid, m_ready, m_data   | sorted_key, sorted_tag, end_of_run, overflowed
//
// Collect takes one beat per cycle. After the closing beat, bottom-up merge runs over two
// banks of two-read-port RAM in ceil(log2(n)) passes; a pass has one check state, one
// setup step per run, a read and a compare/write step per element and one closing step,
// plus one init and one final check per set. Each result passes RAM read, output load
// and show; s_ready stays low from the closing beat until the last result is taken.
// Reset is synchronous, active low, and clears the state and counters but not the RAMs
// or the output register. A stalled result holds in the output register until m_ready.
module tagged_key_merge_sorter_unit #(
    parameter int MAX_ITEMS = tkms_pkg::MAX_ITEMS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tkms_pkg::tkms_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output tkms_pkg::tkms_out_t m_data
);
    import tkms_pkg::*;

    tkms_cmd_t cmd;
    tkms_sts_t sts;

    tkms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    tkms_datapath #(.MAX_ITEMS(MAX_ITEMS)) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

FILE: bench/tagged_key_merge_sorter_unit_tb.sv
module tagged_key_merge_sorter_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tkms_pkg::*;

    localparam int DEPTH = MAX_ITEMS_DEF;
    localparam int RANDOM_BEATS = 250;

    typedef enum int {
        MIX_WIDE,
        MIX_NARROW,
        MIX_EXTREME
    } key_mix_t;

    // Tracks the set being collected, sorts it on its closing beat and checks
    // each sorted beat against the oldest expected one.
    class merge_sort_checker;
        logic signed [KEY_BITS-1:0] held_key[DEPTH];
        logic        [TAG_BITS-1:0] held_tag[DEPTH];
        logic signed [KEY_BITS-1:0] merge_key[DEPTH];
        logic        [TAG_BITS-1:0] merge_tag[DEPTH];
        int         fill;
        bit         dropped;
        tkms_out_t  sorted_due[$];
        int         mismatches;
        int         sets_closed;
        int         overflow_sets;
        int         results_checked;
        int         largest_set;

        function new();
            fill = 0;
            dropped = 0;
            mismatches = 0;
            sets_closed = 0;
            overflow_sets = 0;
            results_checked = 0;
            largest_set = 0;
        endfunction

        function int pending();
            return sorted_due.size();
        endfunction

        // Equal keys: the right part wins, only a strictly smaller left key goes first.
        function void merge_halves(int lo, int nl, int nr);
            int il;
            int ir;
            int src;
            il = 0;
            ir = 0;
            for (int k = 0; k < nl + nr; k++) begin
                if (il < nl && ir < nr) begin
                    if (held_key[lo + il] < held_key[lo + nl + ir]) begin
                        src = lo + il;
                        il++;
                    end else begin
                        src = lo + nl + ir;
                        ir++;
                    end
                end else if (il < nl) begin
                    src = lo + il;
                    il++;
                end else begin
                    src = lo + nl + ir;
                    ir++;
                end
                merge_key[lo + k] = held_key[src];
                merge_tag[lo + k] = held_tag[src];
            end
            for (int k = 0; k < nl + nr; k++) begin
                held_key[lo + k] = merge_key[lo + k];
                held_tag[lo + k] = merge_tag[lo + k];
            end
        endfunction

        // Top-down split (left gets n/2). Spans are listed breadth first, then
        // merged in reverse so that every span is merged after its halves.
        function void sort_held(int count);
            int span_lo[$];
            int span_len[$];
            int idx;
            int half;
            span_lo.push_back(0);
            span_len.push_back(count);
            idx = 0;
            while (idx < span_lo.size()) begin
                half = span_len[idx] / 2;
                if (half > 1) begin
                    span_lo.push_back(span_lo[idx]);
                    span_len.push_back(half);
                end
                if (span_len[idx] - half > 1) begin
                    span_lo.push_back(span_lo[idx] + half);
                    span_len.push_back(span_len[idx] - half);
                end
                idx++;
            end
            for (idx = span_lo.size() - 1; idx >= 0; idx--) begin
                half = span_len[idx] / 2;
                merge_halves(span_lo[idx], half, span_len[idx] - half);
            end
        endfunction

        function void note_pair(tkms_in_t beat);
            tkms_out_t res;
            if (fill < DEPTH) begin
                held_key[fill] = beat.key_value;
                held_tag[fill] = beat.tag_value;
                fill++;
            end else begin
                dropped = 1'b1;
            end
            if (!beat.last_item)
                return;
            if (fill > 0)
                sort_held(fill);
            for (int k = 0; k < fill; k++) begin
                res.sorted_key = held_key[k];
                res.sorted_tag = held_tag[k];
                res.end_of_run = (k == fill - 1);
                res.overflowed = dropped;
                sorted_due.push_back(res);
            end
            sets_closed++;
            if (dropped)
                overflow_sets++;
            if (fill > largest_set)
                largest_set = fill;
            fill = 0;
            dropped = 1'b0;
        endfunction

        function void report_field(string name, logic [KEY_BITS-1:0] want,
                                   logic [KEY_BITS-1:0] got);
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        endfunction

        function void check_sorted(tkms_out_t got);
            tkms_out_t want;
            if (sorted_due.size() == 0) begin
                $display("%0t: unexpected result beat %0h", $time, got);
                mismatches++;
                return;
            end
            want = sorted_due.pop_front();
            results_checked++;
            if (got.sorted_key !== want.sorted_key)
                report_field("sorted_key", want.sorted_key, got.sorted_key);
            if (got.sorted_tag !== want.sorted_tag)
                report_field("sorted_tag", KEY_BITS'(want.sorted_tag),
                             KEY_BITS'(got.sorted_tag));
            if (got.end_of_run !== want.end_of_run)
                report_field("end_of_run", KEY_BITS'(want.end_of_run),
                             KEY_BITS'(got.end_of_run));
            if (got.overflowed !== want.overflowed)
                report_field("overflowed", KEY_BITS'(want.overflowed),
                             KEY_BITS'(got.overflowed));
        endfunction
    endclass

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    tkms_in_t  s_data;
    logic      m_valid;
    logic      m_ready;
    tkms_out_t m_data;

    merge_sort_checker sorter_model = new();
    bit quiet_mode = 1'b0;
    int beats_sent = 0;

    tagged_key_merge_sorter_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sorter_model.note_pair(s_data);
            if (m_valid && m_ready)
                sorter_model.check_sorted(m_data);
        end
    end

    task automatic send_pair(input logic signed [KEY_BITS-1:0] key,
                             input logic [TAG_BITS-1:0] tag, input bit last);
        tkms_in_t beat;
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        beat.key_value = key;
        beat.tag_value = tag;
        beat.last_item = last;
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sorter_model.pending() != 0) @(posedge aclk);
    endtask

    function automatic logic signed [KEY_BITS-1:0] draw_key(key_mix_t mix);
        logic signed [KEY_BITS-1:0] key;
        case (mix)
            MIX_NARROW:  key = $signed($urandom_range(0, 8)) - 4;
            MIX_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       key = {1'b1, {(KEY_BITS-1){1'b0}}};
                    1:       key = {1'b0, {(KEY_BITS-1){1'b1}}};
                    2:       key = '0;
                    default: key = '1;
                endcase
            end
            default:     key = $urandom;
        endcase
        return key;
    endfunction

    // Result side: random stall before each beat, none while quiet.
    initial begin
        int stall;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            stall = quiet_mode ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    initial begin
        int set_len;
        int set_idx;
        int pick;
        key_mix_t mix;

        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // single-entry sets at both key extremes
        send_pair(32'sh7fffffff, 16'hffff, 1'b1);
        send_pair(32'sh80000000, 16'h0000, 1'b1);
        // two equal keys: right one first
        send_pair(32'sd5, 16'h0001, 1'b0);
        send_pair(32'sd5, 16'h0002, 1'b1);
        // zero, minus one and both extremes
        send_pair(32'sd0, 16'h0010, 1'b0);
        send_pair(-32'sd1, 16'h0011, 1'b0);
        send_pair(32'sh7fffffff, 16'h0012, 1'b0);
        send_pair(32'sh80000000, 16'h0013, 1'b1);
        // odd length with ties across the split
        send_pair(32'sd3, 16'h0020, 1'b0);
        send_pair(32'sd3, 16'h0021, 1'b0);
        send_pair(-32'sd3, 16'h0022, 1'b0);
        send_pair(32'sd3, 16'h0023, 1'b0);
        send_pair(-32'sd3, 16'h0024, 1'b1);
        // descending run
        for (int k = 0; k < 6; k++)
            send_pair(32'sd600 - k * 100, 16'(k + 16'h0030), k == 5);
        wait_drained();

        beats_sent = 0;
        set_idx = 0;
        while (beats_sent < RANDOM_BEATS) begin
            pick = $urandom_range(0, 99);
            if (set_idx == 2)
                set_len = DEPTH;
            else if (set_idx == 5)
                set_len = DEPTH + $urandom_range(1, 4);
            else if (pick < 70)
                set_len = $urandom_range(1, 8);
            else if (pick < 95)
                set_len = $urandom_range(9, 24);
            else
                set_len = $urandom_range(40, DEPTH + 2);
            mix = key_mix_t'($urandom_range(0, 2));
            quiet_mode = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                wait_drained();
            for (int k = 0; k < set_len; k++)
                send_pair(draw_key(mix), 16'($urandom), k == set_len - 1);
            set_idx++;
        end
        s_valid <= 1'b0;
        quiet_mode = 1'b0;

        @(posedge aclk);
        while (sorter_model.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sorted %0d sets, %0d result beats checked, largest set %0d entries.",
                 sorter_model.sets_closed, sorter_model.results_checked,
                 sorter_model.largest_set);
        $display("%0d sets overflowed; ties, key extremes and stalls on both sides covered.",
                 sorter_model.overflow_sets);
        if (sorter_model.mismatches == 0 && sorter_model.pending() == 0) begin
            $display("** tagged_key_merge_sorter_unit: PASSED **");
        end else begin
            $display("** tagged_key_merge_sorter_unit: FAILED **");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, sorter_model.pending());
        $display("** tagged_key_merge_sorter_unit: FAILED **");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/tkms_pkg.sv
hdl/tkms_ram.sv
hdl/tkms_datapath.sv
hdl/tkms_ctrl.sv
hdl/tagged_key_merge_sorter_unit.sv
bench/tagged_key_merge_sorter_unit_tb.sv
